@@ rtl/core/tcw_pkg.sv @@
// Types, constants and the control-store microprogram of the text console writer.
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int LINES      = 25;
    localparam int CELL_COUNT = COLUMNS * LINES;

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int CNT_W  = $clog2(CELL_COUNT + 1);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int CELL_W = 16;
    localparam int STEP_W = 5;

    localparam logic [7:0]        SPACE_CODE   = 8'h20;
    localparam logic [7:0]        NEWLINE_CODE = 8'h0A;
    localparam logic [7:0]        ATTR_RESET   = 8'h0F;
    localparam logic [CELL_W-1:0] BLANK_CELL   = {ATTR_RESET, SPACE_CODE};

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } in_word_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic [4:0] cursor_line;
        logic [6:0] cursor_pos;
        logic       did_scroll;
    } out_word_t;

    typedef logic [STEP_W-1:0] step_t;

    // jump conditions: branch to target when true, else fall through
    typedef enum logic [3:0] {
        J_NEXT,
        J_ALWAYS,
        J_NO_ACCEPT,
        J_PUT,
        J_READ,
        J_CLEAR,
        J_NEWLINE,
        J_COL_NOT_END,
        J_ROW_LAST,
        J_COPY_MORE,
        J_FILL_MORE,
        J_OUT_BUSY
    } jmp_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CHAR,
        WR_COPY,
        WR_BLANK
    } wr_op_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_SHIFT,
        RD_SHIFT_NEXT,
        RD_INDEX
    } rd_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLR,
        CNT_INC
    } cnt_op_t;

    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_COL_INC,
        CUR_COL_ZERO,
        CUR_ROW_INC
    } cur_op_t;

    typedef struct packed {
        jmp_t    jmp;
        step_t   target;
        wr_op_t  wr;
        rd_op_t  rd;
        cnt_op_t cnt;
        cur_op_t cur;
        logic    idle;
        logic    set_scroll;
        logic    cap_read;
        logic    emit;
    } ctl_t;

    typedef struct packed {
        logic accept;
        logic cmd_put;
        logic cmd_read;
        logic cmd_clear;
        logic newline;
        logic col_not_end;
        logic row_last;
        logic copy_more;
        logic fill_more;
        logic out_busy;
    } status_t;

    // program entry points
    localparam step_t S_INIT   = 5'd0;
    localparam step_t S_IDLE   = 5'd1;
    localparam step_t S_DISP   = 5'd2;
    localparam step_t S_PUT    = 5'd6;
    localparam step_t S_NL     = 5'd9;
    localparam step_t S_SCROLL = 5'd11;
    localparam step_t S_COPY   = 5'd12;
    localparam step_t S_BLANK  = 5'd13;
    localparam step_t S_READ   = 5'd15;
    localparam step_t S_CLEAR  = 5'd17;
    localparam step_t S_EMIT   = 5'd18;

    function automatic ctl_t ucode(input step_t step);
        ctl_t c;
        c = '0;
        case (step)
            5'd0:  begin c.wr = WR_BLANK; c.cnt = CNT_INC;
                         c.jmp = J_FILL_MORE; c.target = S_INIT; end
            5'd1:  begin c.idle = 1'b1; c.cnt = CNT_CLR;
                         c.jmp = J_NO_ACCEPT; c.target = S_IDLE; end
            5'd2:  begin c.jmp = J_PUT;    c.target = S_PUT;   end
            5'd3:  begin c.jmp = J_READ;   c.target = S_READ;  end
            5'd4:  begin c.jmp = J_CLEAR;  c.target = S_CLEAR; end
            5'd5:  begin c.jmp = J_ALWAYS; c.target = S_EMIT;  end
            5'd6:  begin c.jmp = J_NEWLINE; c.target = S_NL;   end
            5'd7:  begin c.wr = WR_CHAR; c.cur = CUR_COL_INC;  end
            5'd8:  begin c.jmp = J_COL_NOT_END; c.target = S_EMIT; end
            5'd9:  begin c.cur = CUR_COL_ZERO;
                         c.jmp = J_ROW_LAST; c.target = S_SCROLL; end
            5'd10: begin c.cur = CUR_ROW_INC;
                         c.jmp = J_ALWAYS; c.target = S_EMIT; end
            5'd11: begin c.rd = RD_SHIFT; c.set_scroll = 1'b1; end
            5'd12: begin c.wr = WR_COPY; c.rd = RD_SHIFT_NEXT; c.cnt = CNT_INC;
                         c.jmp = J_COPY_MORE; c.target = S_COPY; end
            5'd13: begin c.wr = WR_BLANK; c.cnt = CNT_INC;
                         c.jmp = J_FILL_MORE; c.target = S_BLANK; end
            5'd14: begin c.jmp = J_ALWAYS; c.target = S_EMIT; end
            5'd15: begin c.rd = RD_INDEX; end
            5'd16: begin c.cap_read = 1'b1;
                         c.jmp = J_ALWAYS; c.target = S_EMIT; end
            5'd17: begin c.wr = WR_BLANK; c.cnt = CNT_INC;
                         c.jmp = J_FILL_MORE; c.target = S_CLEAR; end
            5'd18: begin c.emit = 1'b1;
                         c.jmp = J_OUT_BUSY; c.target = S_EMIT; end
            5'd19: begin c.jmp = J_ALWAYS; c.target = S_IDLE; end
            default: begin c.jmp = J_ALWAYS; c.target = S_IDLE; end
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/text_console_writer.sv @@
// Text console writer: cell memory, cursor datapath and microcoded control.
//
//  channel | direction | handshake         | word
//  --------+-----------+-------------------+------------------------------------------
//  in      | input     | in_valid/in_stall | cmd, char_code, cell_index
//  out     | output    | out_valid/out_stall | cell_char, cell_attr, cursor, did_scroll
//  cfg     | input     | cfg_valid/cfg_ready | text_attribute (8 bits)
//
// After reset a clearing pass fills the cell memory with blanks while in is stalled.
// Each accepted word runs its program up to the output load and back to idle: a plain
// character, a read, a newline without scroll and an unused command take equally long, and a
// character that wraps to the next row takes longer. A scroll copies 1920 cells and blanks
// 80, one write per cycle, after a newline or a wrap; a clear blanks all 2000 cells.
// One item is in work at a time; its word waits in the output register while the next
// item is taken and worked on, and each cycle that word stays stalled delays the next load.
module text_console_writer
    import tcw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [7:0] cfg_data
);

    ctl_t    ctl;
    status_t status;

    in_word_t         item_reg;
    logic [7:0]       attr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [7:0]       res_char_reg;
    logic [7:0]       res_attr_reg;
    logic             scroll_reg;
    logic             out_valid_reg;
    out_word_t        out_data_reg;

    logic              in_accept;
    logic              out_load;
    logic              idx_ok;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;
    logic [ADDR_W-1:0] cur_addr;

    tcw_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = !ctl.idle;
    assign in_accept = in_valid && ctl.idle;
    assign out_load  = ctl.emit && !(out_valid_reg && out_stall);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign idx_ok   = 32'(item_reg.cell_index) < CELL_COUNT;
    assign cur_addr = ADDR_W'(32'(row_reg) * COLUMNS) + ADDR_W'(col_reg);

    always_comb
    begin
        status.accept      = in_accept;
        status.cmd_put     = item_reg.cmd == CMD_PUT;
        status.cmd_read    = item_reg.cmd == CMD_READ;
        status.cmd_clear   = item_reg.cmd == CMD_CLEAR;
        status.newline     = item_reg.char_code == NEWLINE_CODE;
        status.col_not_end = col_reg != COL_W'(COLUMNS);
        status.row_last    = row_reg == ROW_W'(LINES - 1);
        status.copy_more   = cnt_reg != CNT_W'(CELL_COUNT - COLUMNS - 1);
        status.fill_more   = cnt_reg != CNT_W'(CELL_COUNT - 1);
        status.out_busy    = out_valid_reg && out_stall;
    end

    // memory ports
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[ADDR_W-1:0];
        ram_wdata = BLANK_CELL;
        case (ctl.wr)
            WR_NONE:  ram_we = 1'b0;
            WR_CHAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_addr;
                ram_wdata = {attr_reg, item_reg.char_code};
            end
            WR_COPY:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            WR_BLANK: ram_we = 1'b1;
            default:  ram_we = 1'b0;
        endcase

        case (ctl.rd)
            RD_SHIFT:      ram_raddr = ADDR_W'(32'(cnt_reg) + COLUMNS);
            RD_SHIFT_NEXT: ram_raddr = ADDR_W'(32'(cnt_reg) + COLUMNS + 1);
            RD_INDEX:      ram_raddr = ADDR_W'(item_reg.cell_index);
            default:       ram_raddr = cnt_reg[ADDR_W-1:0];
        endcase
    end

    always_comb
    begin
        case (ctl.cnt)
            CNT_CLR: cnt_next = '0;
            CNT_INC: cnt_next = cnt_reg + CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase

        col_next = col_reg;
        row_next = row_reg;
        case (ctl.cur)
            CUR_COL_INC:  col_next = col_reg + COL_W'(1);
            CUR_COL_ZERO: col_next = '0;
            CUR_ROW_INC:  row_next = row_reg + ROW_W'(1);
            default:      col_next = col_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            col_reg <= col_next;
            row_reg <= row_next;
            if (cfg_valid)
            begin
                attr_reg <= cfg_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg     <= in_data;
            res_char_reg <= '0;
            res_attr_reg <= '0;
            scroll_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.set_scroll)
            begin
                scroll_reg <= 1'b1;
            end
            if (ctl.cap_read && idx_ok)
            begin
                res_char_reg <= ram_rdata[7:0];
                res_attr_reg <= ram_rdata[15:8];
            end
        end
        if (out_load)
        begin
            out_data_reg.cell_char   <= res_char_reg;
            out_data_reg.cell_attr   <= res_attr_reg;
            out_data_reg.cursor_line <= 5'(row_reg);
            out_data_reg.cursor_pos  <= 7'(col_reg);
            out_data_reg.did_scroll  <= scroll_reg;
        end
    end

    // cursor stays on the grid whenever a new word can be taken
    a_cursor_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.idle |-> (32'(col_reg) < COLUMNS) && (32'(row_reg) < LINES))
        else $error("cursor off the grid while idle");

    // an accepted word always starts a program run
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !ctl.idle)
        else $error("sequencer stayed idle after accept");

    // every cell write lands inside the screen
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (32'(ram_waddr) < CELL_COUNT))
        else $error("cell write out of range");

    // a result is only loaded when the output register is free or draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> !$fell(out_valid_reg))
        else $error("pending result dropped");

endmodule

@@ rtl/core/tcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/tcw_seq.sv @@
// Microcode sequencer: step counter, control store and branch logic.
module tcw_seq
    import tcw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output ctl_t    ctl
);

    step_t pc_reg;
    step_t pc_next;
    logic  take;

    assign ctl = ucode(pc_reg);

    always_comb
    begin
        case (ctl.jmp)
            J_NEXT:        take = 1'b0;
            J_ALWAYS:      take = 1'b1;
            J_NO_ACCEPT:   take = !status.accept;
            J_PUT:         take = status.cmd_put;
            J_READ:        take = status.cmd_read;
            J_CLEAR:       take = status.cmd_clear;
            J_NEWLINE:     take = status.newline;
            J_COL_NOT_END: take = status.col_not_end;
            J_ROW_LAST:    take = status.row_last;
            J_COPY_MORE:   take = status.copy_more;
            J_FILL_MORE:   take = status.fill_more;
            J_OUT_BUSY:    take = status.out_busy;
            default:       take = 1'b0;
        endcase
        pc_next = take ? ctl.target : pc_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_INIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
